// ===== sv/ppid_pkg.sv =====
// Package for the positional PID block: widths, defaults, register indexes
// and the accumulator width rule. No dependencies.
package ppid_pkg;

  localparam int DATA_WIDTH_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int GAIN_W             = 16;
  localparam int OUT_W              = 32;
  localparam int INTEG_W            = 32;
  localparam int REG_IDX_W          = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP    = 2'd0,
    REG_INTEG   = 2'd1,
    REG_DERIV   = 2'd2,
    REG_FEEDFWD = 2'd3
  } ppid_reg_t;

  // Width of the product sum: widest product plus two guard bits for four terms.
  function automatic int ppid_sum_w(int dw);
    int prod_w;
    prod_w = (dw + 1 > INTEG_W) ? (dw + 1 + GAIN_W) : (INTEG_W + GAIN_W);
    return prod_w + 2;
  endfunction

endpackage

// ===== sv/ppid_if.sv =====
// Channel interfaces for the positional PID block: sample input and control output.
// Depends on ppid_pkg.
interface ppid_in_if
  import ppid_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] error_in;
  logic signed [DATA_WIDTH-1:0] target_in;
  logic signed [DATA_WIDTH-1:0] out_limit;

  modport source (output valid, error_in, target_in, out_limit, input ready);
  modport sink (input valid, error_in, target_in, out_limit, output ready);
endinterface

interface ppid_out_if
  import ppid_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] control_out;

  modport source (output valid, control_out, input ready);
  modport sink (input valid, control_out, output ready);
endinterface

// ===== sv/ppid_front.sv =====
// Front stages: input register with error and target history, then the
// proportional, derivative and feedforward products summed into one register.
// Depends on ppid_pkg and ppid_in_if.
module ppid_front
  import ppid_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int SUM_W = ppid_sum_w(DATA_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ppid_in_if.sink                      in_ch,
  input  logic signed [GAIN_W-1:0]     prop_gain,
  input  logic signed [GAIN_W-1:0]     deriv_gain,
  input  logic signed [GAIN_W-1:0]     feedfwd_gain,
  output logic                         s1_valid,
  input  logic                         s1_ready,
  output logic signed [SUM_W-1:0]      s1_psum,
  output logic signed [DATA_WIDTH-1:0] s1_err,
  output logic        [DATA_WIDTH-1:0] s1_lim
);

  localparam int DW = DATA_WIDTH;
  localparam logic [DW-1:0] LIM_MAX = {1'b0, {(DW-1){1'b1}}};

  logic                 s0_v_r;
  logic signed [DW-1:0] s0_err_r;
  logic        [DW-1:0] s0_lim_r;
  logic signed [DW:0]   s0_de_r;
  logic signed [DW:0]   s0_dt_r;

  logic signed [DW-1:0] prev_err_r;
  logic signed [DW-1:0] older_err_r;
  logic signed [DW-1:0] prev_tgt_r;

  logic                 s1_v_r;
  logic signed [SUM_W-1:0] psum_r;
  logic signed [DW-1:0] err1_r;
  logic        [DW-1:0] lim1_r;

  logic en0;
  logic en1;
  logic signed [DW-1:0] lim_neg;
  logic        [DW-1:0] lim_mag;
  logic signed [DW:0]   de_nxt;
  logic signed [DW:0]   dt_nxt;
  logic signed [GAIN_W+DW-1:0] prod_p;
  logic signed [GAIN_W+DW:0]   prod_d;
  logic signed [GAIN_W+DW:0]   prod_f;
  logic signed [SUM_W-1:0]     psum_nxt;

  assign en1 = !s1_v_r || s1_ready;
  assign en0 = !s0_v_r || en1;
  assign in_ch.ready = en0;

  always_comb begin
    lim_neg = -in_ch.out_limit;
    if (in_ch.out_limit[DW-1]) begin
      lim_mag = lim_neg[DW-1] ? LIM_MAX : lim_neg;
    end else begin
      lim_mag = in_ch.out_limit;
    end
    de_nxt = (DW+1)'(prev_err_r) - (DW+1)'(older_err_r);
    dt_nxt = (DW+1)'(in_ch.target_in) - (DW+1)'(prev_tgt_r);
  end

  always_comb begin
    prod_p   = prop_gain * s0_err_r;
    prod_d   = deriv_gain * s0_de_r;
    prod_f   = feedfwd_gain * s0_dt_r;
    psum_nxt = SUM_W'(prod_p) + SUM_W'(prod_d) + SUM_W'(prod_f);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      prev_err_r  <= '0;
      older_err_r <= '0;
      prev_tgt_r  <= '0;
    end else begin
      if (en0) begin
        s0_v_r <= in_ch.valid;
        if (in_ch.valid) begin
          older_err_r <= prev_err_r;
          prev_err_r  <= in_ch.error_in;
          prev_tgt_r  <= in_ch.target_in;
        end
      end
      if (en1) begin
        s1_v_r <= s0_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_ch.valid) begin
      s0_err_r <= in_ch.error_in;
      s0_lim_r <= lim_mag;
      s0_de_r  <= de_nxt;
      s0_dt_r  <= dt_nxt;
    end
    if (en1 && s0_v_r) begin
      psum_r <= psum_nxt;
      err1_r <= s0_err_r;
      lim1_r <= s0_lim_r;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_psum  = psum_r;
  assign s1_err   = err1_r;
  assign s1_lim   = lim1_r;

endmodule

// ===== sv/ppid_core.sv =====
// Integrator stage: integral product, final sum, shift and saturation, the
// conditional integration decision and the output register.
// Depends on ppid_pkg and ppid_out_if.
module ppid_core
  import ppid_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  localparam int SUM_W = ppid_sum_w(DATA_WIDTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [GAIN_W-1:0]     integ_gain,
  input  logic                         s1_valid,
  output logic                         s1_ready,
  input  logic signed [SUM_W-1:0]      s1_psum,
  input  logic signed [DATA_WIDTH-1:0] s1_err,
  input  logic        [DATA_WIDTH-1:0] s1_lim,
  ppid_out_if.source                   out_ch
);

  localparam int DW = DATA_WIDTH;
  localparam logic signed [OUT_W-1:0] S32_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] S32_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic                      out_v_r;
  logic signed [OUT_W-1:0]   ctrl_r;
  logic signed [INTEG_W-1:0] integ_r;

  logic                      en_o;
  logic                      take;
  logic signed [GAIN_W+INTEG_W-1:0] prod_i;
  logic signed [SUM_W-1:0]   acc;
  logic signed [SUM_W-1:0]   acc_sh;
  logic signed [OUT_W-1:0]   ctrl_nxt;
  logic signed [OUT_W:0]     ctrl_x;
  logic signed [OUT_W:0]     lim_x;
  logic                      err_pos;
  logic                      hold;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W-1:0] integ_sat;

  assign en_o     = !out_v_r || out_ch.ready;
  assign take     = s1_valid && en_o;
  assign s1_ready = en_o;

  always_comb begin
    prod_i = integ_gain * integ_r;
    acc    = SUM_W'(prod_i) + s1_psum;
    acc_sh = acc >>> GAIN_FRAC_BITS;
    if (!acc_sh[SUM_W-1] && (|acc_sh[SUM_W-2:OUT_W-1])) begin
      ctrl_nxt = S32_MAX;
    end else if (acc_sh[SUM_W-1] && !(&acc_sh[SUM_W-2:OUT_W-1])) begin
      ctrl_nxt = S32_MIN;
    end else begin
      ctrl_nxt = acc_sh[OUT_W-1:0];
    end

    ctrl_x  = (OUT_W+1)'(ctrl_nxt);
    lim_x   = $signed((OUT_W+1)'(s1_lim));
    err_pos = !s1_err[DW-1] && (s1_err != '0);
    hold    = ((ctrl_x > lim_x) && err_pos) || ((ctrl_x < -lim_x) && !err_pos);

    isum = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(s1_err);
    if (isum[INTEG_W] != isum[INTEG_W-1]) begin
      integ_sat = isum[INTEG_W] ? S32_MIN : S32_MAX;
    end else begin
      integ_sat = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      integ_r <= '0;
    end else begin
      if (en_o) begin
        out_v_r <= s1_valid;
      end
      if (take && !hold) begin
        integ_r <= integ_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.control_out = ctrl_r;

  // The integral moves only when a beat passes into the output register unheld.
  a_integ_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(integ_r))
    else $error("integral changed without a beat");

  a_integ_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hold) |=> $stable(integ_r))
    else $error("integral changed while anti-windup held it");

  a_out_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ch.ready) |=> (out_v_r && $stable(ctrl_r)))
    else $error("stalled result was lost or changed");

endmodule

// ===== sv/positional_pid_antiwindup.sv =====
// Top level of the positional PID controller with conditional-integration
// anti-windup: gain registers and the two pipeline parts.
// Depends on ppid_pkg, ppid_if, ppid_front and ppid_core.
//
//   Channel  Direction  Handshake          Payload
//   in_ch    sink       valid/ready        error_in, target_in, out_limit
//   out_ch   source     valid/ready        control_out
//   cfg      write      cfg_we             cfg_idx, cfg_wdata
//
// One sample is accepted per cycle unless the output stalls. The integrator
// feedback loop in the output stage sets the rate. Reset (rst_n low,
// synchronous) clears the gains, history and integral. A stalled output holds
// its result while the two earlier stages keep filling.
module positional_pid_antiwindup
  import ppid_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [REG_IDX_W-1:0]  cfg_idx,
  input  logic [GAIN_W-1:0]     cfg_wdata,
  ppid_in_if.sink               in_ch,
  ppid_out_if.source            out_ch
);

  localparam int SUM_W = ppid_sum_w(DATA_WIDTH);

  logic signed [GAIN_W-1:0] kp_r;
  logic signed [GAIN_W-1:0] ki_r;
  logic signed [GAIN_W-1:0] kd_r;
  logic signed [GAIN_W-1:0] kf_r;

  logic                         s1_valid;
  logic                         s1_ready;
  logic signed [SUM_W-1:0]      s1_psum;
  logic signed [DATA_WIDTH-1:0] s1_err;
  logic        [DATA_WIDTH-1:0] s1_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      ki_r <= '0;
      kd_r <= '0;
      kf_r <= '0;
    end else if (cfg_we) begin
      unique case (ppid_reg_t'(cfg_idx))
        REG_PROP:    kp_r <= cfg_wdata;
        REG_INTEG:   ki_r <= cfg_wdata;
        REG_DERIV:   kd_r <= cfg_wdata;
        REG_FEEDFWD: kf_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ppid_front #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .prop_gain    (kp_r),
    .deriv_gain   (kd_r),
    .feedfwd_gain (kf_r),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1_psum      (s1_psum),
    .s1_err       (s1_err),
    .s1_lim       (s1_lim)
  );

  ppid_core #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .integ_gain (ki_r),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_psum    (s1_psum),
    .s1_err     (s1_err),
    .s1_lim     (s1_lim),
    .out_ch     (out_ch)
  );

endmodule

// ===== sim/ppid_control_checker.sv =====
// Checker for the positional PID block: predicts each control value from the
// gain writes and input beats and compares it with the output beats.
// Depends on ppid_pkg.
module ppid_control_checker
  import ppid_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [REG_IDX_W-1:0]         cfg_idx,
  input  logic [GAIN_W-1:0]            cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] error_in,
  input  logic signed [DATA_WIDTH-1:0] target_in,
  input  logic signed [DATA_WIDTH-1:0] out_limit,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [OUT_W-1:0]      control_out,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           held
);

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint LIM_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;

  longint prop_gain, integ_gain, deriv_gain, feedfwd_gain;
  longint integral, prev_err, older_err, prev_tgt;
  bit     integ_frozen;

  logic signed [OUT_W-1:0] expected_ctrl[$];
  logic signed [OUT_W-1:0] want;

  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Computes the control value of one sample and advances the controller state.
  function automatic logic signed [OUT_W-1:0] advance_controller(
    input longint err, input longint tgt, input longint lim);
    longint mag;
    longint acc;
    longint ctrl;
    mag = (lim < 0) ? -lim : lim;
    if (mag > LIM_MAX) mag = LIM_MAX;
    acc = prop_gain * err + integ_gain * integral
        + deriv_gain * (prev_err - older_err) + feedfwd_gain * (tgt - prev_tgt);
    ctrl = clamp32(acc >>> GAIN_FRAC_BITS);
    integ_frozen = (ctrl > mag && err > 0) || (ctrl < -mag && err <= 0);
    if (!integ_frozen) integral = clamp32(integral + err);
    older_err = prev_err;
    prev_err  = err;
    prev_tgt  = tgt;
    return ctrl[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prop_gain    = 0;
      integ_gain   = 0;
      deriv_gain   = 0;
      feedfwd_gain = 0;
      integral     = 0;
      prev_err     = 0;
      older_err    = 0;
      prev_tgt     = 0;
      expected_ctrl.delete();
      fail_count <= 0;
      pending    <= 0;
      checked    <= 0;
      held       <= 0;
    end else begin
      if (cfg_we) begin
        case (ppid_reg_t'(cfg_idx))
          REG_PROP:    prop_gain    = longint'($signed(cfg_wdata));
          REG_INTEG:   integ_gain   = longint'($signed(cfg_wdata));
          REG_DERIV:   deriv_gain   = longint'($signed(cfg_wdata));
          REG_FEEDFWD: feedfwd_gain = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_ctrl.size() == 0) begin
          $error("control_out: unexpected beat, expected none, actual %0d", control_out);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_ctrl.pop_front();
          if (control_out !== want) begin
            $error("control_out mismatch: expected %0d, actual %0d", want, control_out);
            fail_count <= fail_count + 1;
          end
          checked <= checked + 1;
        end
      end
      if (in_valid && in_ready) begin
        expected_ctrl.push_back(advance_controller(error_in, target_in, out_limit));
        held <= held + int'(integ_frozen);
      end
      pending <= expected_ctrl.size();
    end
  end

endmodule

// ===== sim/positional_pid_antiwindup_tb.sv =====
// Testbench top for the positional PID block: drives samples and gain writes
// with random idling, and gives the verdict from the checker's counts.
// Depends on ppid_pkg, ppid_if, positional_pid_antiwindup and ppid_control_checker.
module positional_pid_antiwindup_tb;
  import ppid_pkg::*;

  localparam int DW          = DATA_WIDTH_DEF;
  localparam int STALL_LIMIT = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;

  bit steady;
  int gain_sets;
  int idle_cycles;
  int fail_count, pending, checked, held;

  ppid_in_if #(.DATA_WIDTH(DW)) in_ch ();
  ppid_out_if                   out_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_pid_antiwindup u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ppid_control_checker #(.DATA_WIDTH(DW)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .error_in    (in_ch.error_in),
    .target_in   (in_ch.target_in),
    .out_limit   (in_ch.out_limit),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .control_out (out_ch.control_out),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .held        (held)
  );

  function automatic logic signed [DW-1:0] pick_field();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3, 4:    return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:          return 16'h7fff;
      1:          return 16'h8000;
      2:          return '0;
      3, 4, 5:    return 16'($urandom_range(0, 2047)) - 16'd1024;
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                            input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] fd);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PROP;
    cfg_wdata <= kp;
    @(posedge clk);
    cfg_idx   <= REG_INTEG;
    cfg_wdata <= ki;
    @(posedge clk);
    cfg_idx   <= REG_DERIV;
    cfg_wdata <= kd;
    @(posedge clk);
    cfg_idx   <= REG_FEEDFWD;
    cfg_wdata <= fd;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gain_sets++;
  endtask

  task automatic send_sample(input logic signed [DW-1:0] err, input logic signed [DW-1:0] tgt,
                             input logic signed [DW-1:0] lim);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.error_in  <= err;
    in_ch.target_in <= tgt;
    in_ch.out_limit <= lim;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      send_sample(pick_field(), pick_field(), pick_field());
      if ($urandom_range(0, 63) == 0) wait_idle();
    end
  endtask

  task automatic run_windup(input logic signed [DW-1:0] err, input int n);
    for (int i = 0; i < n; i++) begin
      send_sample(err, pick_field(), pick_field());
    end
  endtask

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_PROP;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.error_in  <= '0;
    in_ch.target_in <= '0;
    in_ch.out_limit <= '0;
    steady    = 1'b0;
    gain_sets = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Fractional gains make the floor of negative sums visible.
    load_gains(16'd257, 16'd19, -16'd385, 16'd129);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sd1, 16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0, 16'sd0);
    send_sample(16'sh7fff, 16'sh8000, 16'sd100);
    send_sample(16'sh8000, 16'sh7fff, -16'sd100);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd100, 16'sd50, 16'sd1000);
    send_sample(-16'sd5, 16'sd3, 16'sd5);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    load_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'sh7fff, 16'sh7fff, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sd0);
    send_sample(16'sd1, -16'sd1, 16'sh8000);
    send_sample(-16'sd1, 16'sd1, 16'sh7fff);
    send_sample(16'sd0, 16'sd0, 16'sd1);
    load_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd3, -16'sd3, 16'sd1);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       load_gains('0, '0, '0, '0);
        1:       load_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        2:       load_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      endcase
      steady = (p == 3);
      random_samples(160);
    end

    // With all gains at zero the integral never freezes, so it climbs well past 2^24.
    steady = 1'b1;
    load_gains('0, '0, '0, '0);
    run_windup(16'sh7fff, 600);

    // A large integral times an extreme gain drives the output into both bounds.
    steady = 1'b0;
    load_gains(pick_gain(), 16'h8000, pick_gain(), pick_gain());
    random_samples(30);
    load_gains(pick_gain(), 16'h7fff, pick_gain(), pick_gain());
    random_samples(30);

    wait_idle();
    repeat (5) @(posedge clk);
    $display("Checked %0d control results over %0d gain settings; integral held on %0d samples.",
             checked, gain_sets, held);
    $display("The run pushed the integral past 2^24 and saturated the output at both bounds.");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
